// ----- rtl/ptc_pkg.sv -----
// Shared types, constants and the keyword table of the Pascal token classifier.
package ptc_pkg;

    localparam int MAX_KEYWORD_LEN = 14;
    localparam int SEG_LEN_BITS    = 16;
    localparam int CHAR_W          = 8;
    localparam int FMT_W           = 3;
    localparam int ILEN_W          = $clog2(MAX_KEYWORD_LEN + 2);
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = ((SEG_LEN_BITS + FMT_W + 7) / 8) * 8;
    localparam int QDEPTH          = 4;     // power of two
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int KW_N            = 84;

    localparam logic [SEG_LEN_BITS-1:0] LEN_MAX = '1;

    localparam logic [FMT_W-1:0] FMT_DEFAULT   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_KEYWORD   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_STRING    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_COMMENT   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_DIRECTIVE = 3'd4;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_DIG0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_WS,
        MODE_STR,
        MODE_SLASH,
        MODE_LINE,
        MODE_BRACE,
        MODE_LPAR,
        MODE_PCOM,
        MODE_IDENT,
        MODE_OTHER
    } mode_t;

    typedef logic [CHAR_W*MAX_KEYWORD_LEN-1:0] kw_word_t;

    // Words are right-justified: the first character sits in the highest used byte.
    localparam kw_word_t KW_TABLE [KW_N] = '{
        "absolute", "and", "array", "as", "asm", "assembler", "begin", "break",
        "case", "class", "const", "constructor", "continue", "destructor",
        "dispinterface", "dispose", "div", "do", "downto", "else", "end",
        "except", "exit", "exports", "external", "false", "far", "file",
        "finalization", "finally", "for", "forward", "function", "goto", "if",
        "implementation", "in", "inherited", "initialization", "inline",
        "interface", "interrupt", "is", "label", "library", "mod", "near", "new",
        "nil", "not", "object", "of", "on", "operator", "or", "out", "packed",
        "private", "procedure", "program", "property", "raise", "record",
        "repeat", "resourcestring", "self", "set", "shl", "shr", "string",
        "then", "threadvar", "to", "true", "try", "type", "unit", "until",
        "uses", "var", "virtual", "while", "with", "xor"
    };

    typedef struct packed {
        logic [SEG_LEN_BITS-1:0] seg_length;
        logic [FMT_W-1:0]        seg_format;
        logic                    final_segment;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t d0;
        result_t d1;
    } push_req_t;

    typedef struct packed {
        logic              room;   // space for two more results
        logic [QPTR_W:0]   level;
    } queue_stat_t;

    function automatic int kw_len(kw_word_t w);
        int n;
        n = 0;
        for (int k = 0; k < MAX_KEYWORD_LEN; k++) begin
            if (w[CHAR_W*k +: CHAR_W] != '0) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [FMT_W-1:0] seg_fmt(mode_t m, logic dir, logic kw);
        logic [FMT_W-1:0] f;
        case (m)
            MODE_STR:   f = FMT_STRING;
            MODE_LINE:  f = FMT_COMMENT;
            MODE_BRACE: f = dir ? FMT_DIRECTIVE : FMT_COMMENT;
            MODE_PCOM:  f = dir ? FMT_DIRECTIVE : FMT_COMMENT;
            MODE_IDENT: f = kw ? FMT_KEYWORD : FMT_DEFAULT;
            default:    f = FMT_DEFAULT;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/ptc_kw_match.sv -----
// Parallel compare of the buffered identifier against the keyword table.
module ptc_kw_match (
    input  logic [ptc_pkg::CHAR_W-1:0] chars [ptc_pkg::MAX_KEYWORD_LEN],
    input  logic [ptc_pkg::ILEN_W-1:0] len,
    output logic                       hit
);

    logic [ptc_pkg::KW_N-1:0] hit_vec;

    for (genvar i = 0; i < ptc_pkg::KW_N; i++) begin : g_kw
        localparam int L = ptc_pkg::kw_len(ptc_pkg::KW_TABLE[i]);
        logic [L-1:0] eq;
        for (genvar j = 0; j < L; j++) begin : g_ch
            assign eq[j] = (chars[j] ==
                            ptc_pkg::KW_TABLE[i][ptc_pkg::CHAR_W*(L-1-j) +: ptc_pkg::CHAR_W]);
        end
        assign hit_vec[i] = (len == ptc_pkg::ILEN_W'(L)) && (&eq);
    end

    assign hit = |hit_vec;

endmodule

// ----- rtl/ptc_out_queue.sv -----
// Small result queue: takes up to two results a cycle, hands out one while the sink is ready.
module ptc_out_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ptc_pkg::push_req_t              push,
    output ptc_pkg::queue_stat_t            stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptc_pkg::OUT_TDATA_W-1:0] m_tdata,   // seg_length, seg_format
    output logic                            m_tlast    // final_segment
);

    ptc_pkg::result_t               mem_reg [ptc_pkg::QDEPTH];
    logic [ptc_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [ptc_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [ptc_pkg::QPTR_W:0]       cnt_reg, cnt_next;
    logic [ptc_pkg::QPTR_W-1:0]     wr_plus1;
    logic                           pop;
    ptc_pkg::result_t               head;

    assign pop      = m_tvalid && m_tready;
    assign wr_plus1 = wr_reg + 1'b1;
    assign head     = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg + ptc_pkg::QPTR_W'(push.v0) + ptc_pkg::QPTR_W'(push.v1);
        rd_next  = rd_reg + ptc_pkg::QPTR_W'(pop);
        cnt_next = cnt_reg + (ptc_pkg::QPTR_W+1)'(push.v0) + (ptc_pkg::QPTR_W+1)'(push.v1)
                   - (ptc_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem_reg[wr_reg] <= push.d0;
        end
        if (push.v1) begin
            mem_reg[wr_plus1] <= push.d1;
        end
    end

    assign stat.level = cnt_reg;
    assign stat.room  = (cnt_reg <= (ptc_pkg::QPTR_W+1)'(ptc_pkg::QDEPTH - 2));
    assign m_tvalid   = (cnt_reg != '0);
    assign m_tdata    = ptc_pkg::OUT_TDATA_W'({head.seg_format, head.seg_length});
    assign m_tlast    = head.final_segment;

endmodule

// ----- rtl/pascal_token_classifier_core.sv -----
// Top level of the Pascal token classifier: lexer state machine and stream ports.
//
// Takes one source byte per cycle and reports each highlight segment (length, format,
// final flag) when it closes. A byte waits in the input register, where the mode update
// and the keyword compare run, until the queue has room; its results are then written
// into the result queue, whose head drives m_. A byte closes zero, one or two segments;
// results go into a four-entry queue and leave one per cycle while the sink is ready, so
// the input runs at one byte per cycle as long as the queue has room for two results,
// i.e. while the sink keeps up with the segment rate. The single result port of the
// queue sets the output at one segment per cycle while the sink is ready.
module pascal_token_classifier_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptc_pkg::IN_TDATA_W-1:0]  s_tdata,   // text_byte
    input  logic                            s_tlast,   // end_of_text
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ptc_pkg::OUT_TDATA_W-1:0] m_tdata,   // seg_length, seg_format
    output logic                            m_tlast    // final_segment
);

    localparam int MK = ptc_pkg::MAX_KEYWORD_LEN;
    localparam int CW = ptc_pkg::CHAR_W;
    localparam int LW = ptc_pkg::SEG_LEN_BITS;
    localparam int IW = ptc_pkg::ILEN_W;

    // input register
    logic            in_valid_reg;
    logic [CW-1:0]   in_byte_reg;
    logic            in_eot_reg;

    // lexer state
    ptc_pkg::mode_t  mode_reg, mode_next;
    logic [LW-1:0]   cnt_reg, cnt_next;
    logic            dir_reg, dir_next;
    logic            chk_reg, chk_next;
    logic            star_reg, star_next;
    logic [IW-1:0]   ilen_reg, ilen_next;
    logic [CW-1:0]   ichars_reg  [MK];
    logic [CW-1:0]   ichars_next [MK];

    ptc_pkg::queue_stat_t qstat;
    ptc_pkg::push_req_t   push;
    logic                 proc;

    // byte classes
    logic is_ws, is_nl, is_lp, is_rp, is_lb, is_rb, is_star, is_quote, is_slash;
    logic is_dig, is_let, is_upper, is_oth;
    logic [CW-1:0] lower_byte;

    // decode results
    ptc_pkg::mode_t mode_mid, start_mode;
    logic           extend, closes, dir_mid, chk_mid, star_mid;
    logic           kw_cur, kw_next;
    logic [LW-1:0]  cnt_inc;
    logic           id_push;
    logic [IW-1:0]  ilen_base;

    assign proc     = in_valid_reg && qstat.room;
    assign s_tready = !in_valid_reg || qstat.room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    always_comb begin
        is_ws    = (in_byte_reg == ptc_pkg::CH_SPACE) || (in_byte_reg == ptc_pkg::CH_TAB) ||
                   (in_byte_reg == ptc_pkg::CH_VT)    || (in_byte_reg == ptc_pkg::CH_FF);
        is_nl    = (in_byte_reg == ptc_pkg::CH_CR) || (in_byte_reg == ptc_pkg::CH_LF);
        is_lp    = (in_byte_reg == ptc_pkg::CH_LPAREN);
        is_rp    = (in_byte_reg == ptc_pkg::CH_RPAREN);
        is_lb    = (in_byte_reg == ptc_pkg::CH_LBRACE);
        is_rb    = (in_byte_reg == ptc_pkg::CH_RBRACE);
        is_star  = (in_byte_reg == ptc_pkg::CH_STAR);
        is_quote = (in_byte_reg == ptc_pkg::CH_QUOTE);
        is_slash = (in_byte_reg == ptc_pkg::CH_SLASH);
        is_dig   = (in_byte_reg >= ptc_pkg::CH_DIG0) && (in_byte_reg <= ptc_pkg::CH_DIG9);
        is_upper = (in_byte_reg >= ptc_pkg::CH_UC_A) && (in_byte_reg <= ptc_pkg::CH_UC_Z);
        is_let   = is_upper || (in_byte_reg == ptc_pkg::CH_UNDER) ||
                   ((in_byte_reg >= ptc_pkg::CH_LC_A) && (in_byte_reg <= ptc_pkg::CH_LC_Z));
        is_oth   = !(is_ws || is_nl || is_lp || is_rp || is_lb || is_rb || is_star ||
                     is_quote || is_slash || is_dig || is_let);
        lower_byte = is_upper ? (in_byte_reg | ptc_pkg::CASE_BIT) : in_byte_reg;
    end

    // per-mode decision: does the byte extend the open segment, and does it close it
    always_comb begin
        mode_mid = mode_reg;
        dir_mid  = dir_reg;
        chk_mid  = chk_reg;
        star_mid = star_reg;
        extend   = 1'b0;
        closes   = 1'b0;
        case (mode_reg)
            ptc_pkg::MODE_WS: begin
                extend = is_ws || is_nl;
            end
            ptc_pkg::MODE_STR: begin
                extend = !is_nl;
                closes = is_quote;
            end
            ptc_pkg::MODE_SLASH: begin
                if (is_slash) begin
                    extend   = 1'b1;
                    mode_mid = ptc_pkg::MODE_LINE;
                end
            end
            ptc_pkg::MODE_LINE: begin
                extend = !is_nl;
            end
            ptc_pkg::MODE_BRACE: begin
                if (chk_reg) begin
                    dir_mid = (in_byte_reg == ptc_pkg::CH_DOLLAR);
                    chk_mid = 1'b0;
                end
                extend = 1'b1;
                closes = is_rb;
            end
            ptc_pkg::MODE_LPAR: begin
                if (is_star) begin
                    extend   = 1'b1;
                    mode_mid = ptc_pkg::MODE_PCOM;
                    chk_mid  = 1'b1;
                    star_mid = 1'b0;
                end
            end
            ptc_pkg::MODE_PCOM: begin
                if (chk_reg) begin
                    dir_mid = (in_byte_reg == ptc_pkg::CH_DOLLAR);
                    chk_mid = 1'b0;
                end
                extend   = 1'b1;
                closes   = is_rp && star_reg;
                star_mid = is_star;
            end
            ptc_pkg::MODE_IDENT: begin
                extend = is_let || is_dig;
            end
            ptc_pkg::MODE_OTHER: begin
                extend = is_rp || is_rb || is_star || is_dig || is_oth;
            end
            default: begin
                mode_mid = ptc_pkg::MODE_IDLE;
            end
        endcase
    end

    // identifier buffer: appended in an open identifier, restarted by a new one
    always_comb begin
        id_push     = extend ? (mode_reg == ptc_pkg::MODE_IDENT) : is_let;
        ilen_base   = extend ? ilen_reg : '0;
        ilen_next   = ilen_base;
        ichars_next = ichars_reg;
        if (id_push) begin
            for (int k = 0; k < MK; k++) begin
                if (ilen_base == IW'(k)) begin
                    ichars_next[k] = lower_byte;
                end
            end
            if (ilen_base <= IW'(MK)) begin
                ilen_next = ilen_base + 1'b1;
            end
        end
    end

    ptc_kw_match u_kw_cur (
        .chars (ichars_reg),
        .len   (ilen_reg),
        .hit   (kw_cur)
    );

    ptc_kw_match u_kw_next (
        .chars (ichars_next),
        .len   (ilen_next),
        .hit   (kw_next)
    );

    always_comb begin
        if (is_ws || is_nl) begin
            start_mode = ptc_pkg::MODE_WS;
        end else if (is_quote) begin
            start_mode = ptc_pkg::MODE_STR;
        end else if (is_slash) begin
            start_mode = ptc_pkg::MODE_SLASH;
        end else if (is_lb) begin
            start_mode = ptc_pkg::MODE_BRACE;
        end else if (is_lp) begin
            start_mode = ptc_pkg::MODE_LPAR;
        end else if (is_let) begin
            start_mode = ptc_pkg::MODE_IDENT;
        end else begin
            start_mode = ptc_pkg::MODE_OTHER;
        end
    end

    assign cnt_inc = (cnt_reg == ptc_pkg::LEN_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // results and next state
    always_comb begin
        push      = '0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        dir_next  = dir_reg;
        chk_next  = chk_reg;
        star_next = star_reg;
        if (extend) begin
            cnt_next  = cnt_inc;
            dir_next  = dir_mid;
            chk_next  = chk_mid;
            star_next = star_mid;
            mode_next = mode_mid;
            if (closes || in_eot_reg) begin
                push.v0                = 1'b1;
                push.d0.seg_length     = cnt_inc;
                push.d0.seg_format     = ptc_pkg::seg_fmt(mode_mid, dir_mid, kw_next);
                push.d0.final_segment  = in_eot_reg;
                mode_next              = ptc_pkg::MODE_IDLE;
            end
        end else begin
            cnt_next  = LW'(1);
            dir_next  = 1'b0;
            chk_next  = (start_mode == ptc_pkg::MODE_BRACE);
            star_next = 1'b0;
            mode_next = in_eot_reg ? ptc_pkg::MODE_IDLE : start_mode;
            if (mode_mid != ptc_pkg::MODE_IDLE) begin
                push.v0               = 1'b1;
                push.d0.seg_length    = cnt_reg;
                push.d0.seg_format    = ptc_pkg::seg_fmt(mode_mid, dir_mid, kw_cur);
                push.d0.final_segment = 1'b0;
                if (in_eot_reg) begin
                    push.v1               = 1'b1;
                    push.d1.seg_length    = LW'(1);
                    push.d1.seg_format    = ptc_pkg::seg_fmt(start_mode, 1'b0, kw_next);
                    push.d1.final_segment = 1'b1;
                end
            end else if (in_eot_reg) begin
                push.v0               = 1'b1;
                push.d0.seg_length    = LW'(1);
                push.d0.seg_format    = ptc_pkg::seg_fmt(start_mode, 1'b0, kw_next);
                push.d0.final_segment = 1'b1;
            end
        end
        if (!proc) begin
            push.v0 = 1'b0;
            push.v1 = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ptc_pkg::MODE_IDLE;
            cnt_reg  <= '0;
            dir_reg  <= 1'b0;
            chk_reg  <= 1'b0;
            star_reg <= 1'b0;
            ilen_reg <= '0;
        end else if (proc) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            dir_reg  <= dir_next;
            chk_reg  <= chk_next;
            star_reg <= star_next;
            ilen_reg <= ilen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            ichars_reg <= ichars_next;
        end
    end

    ptc_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .stat     (qstat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.level <= (ptc_pkg::QPTR_W+1)'(ptc_pkg::QDEPTH))
        else $error("result queue overflow");

    a_eot_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_eot_reg |=> mode_reg == ptc_pkg::MODE_IDLE)
        else $error("segment left open after end of text");

    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> push.v0 && !push.d0.final_segment && push.d1.final_segment)
        else $error("second result without a first");

    a_open_len: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != ptc_pkg::MODE_IDLE |-> cnt_reg != '0)
        else $error("open segment with zero length");
`endif

endmodule

// ----- tb/pascal_token_classifier_core_test.sv -----
// Self-checking testbench for the Pascal token classifier core.
module pascal_token_classifier_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptc_pkg::*;

    typedef enum logic [3:0] {
        CC_WS, CC_NL, CC_LP, CC_RP, CC_LB, CC_RB,
        CC_STAR, CC_QUOTE, CC_SLASH, CC_LET, CC_DIG, CC_OTH
    } char_cls_t;

    typedef enum int {
        TK_KEYWORD, TK_IDENT, TK_NUMBER, TK_SPACE, TK_STRING,
        TK_BRACE, TK_PAREN, TK_LINE, TK_PUNCT, TK_NOISE
    } tok_kind_t;

    typedef struct {
        logic [CHAR_W-1:0] b;
        logic              last;
    } src_byte_t;

    localparam int RANDOM_BYTES = 420;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 40;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    pascal_token_classifier_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    string kw_list [KW_N] = '{
        "absolute", "and", "array", "as", "asm", "assembler", "begin", "break",
        "case", "class", "const", "constructor", "continue", "destructor",
        "dispinterface", "dispose", "div", "do", "downto", "else", "end",
        "except", "exit", "exports", "external", "false", "far", "file",
        "finalization", "finally", "for", "forward", "function", "goto", "if",
        "implementation", "in", "inherited", "initialization", "inline",
        "interface", "interrupt", "is", "label", "library", "mod", "near", "new",
        "nil", "not", "object", "of", "on", "operator", "or", "out", "packed",
        "private", "procedure", "program", "property", "raise", "record",
        "repeat", "resourcestring", "self", "set", "shl", "shr", "string",
        "then", "threadvar", "to", "true", "try", "type", "unit", "until",
        "uses", "var", "virtual", "while", "with", "xor"
    };

    src_byte_t   text_q [$];
    result_t     seg_q [$];
    src_byte_t   nxt_byte;
    int          err_cnt   = 0;
    int          seg_seen  = 0;
    int          cyc       = 0;
    int          cyc_limit = 2000000;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic        calm;

    // lexer shadow state
    mode_t                   lx_mode     = MODE_IDLE;
    logic [SEG_LEN_BITS-1:0] run_len     = '0;
    logic                    dir_seen    = 1'b0;
    logic                    want_dollar = 1'b0;
    logic                    last_star   = 1'b0;
    logic [CHAR_W-1:0]       word_buf [MAX_KEYWORD_LEN];
    int                      word_len    = 0;

    assign calm = (seg_seen >= 120) && (seg_seen < 220);

    function automatic char_cls_t classify(logic [CHAR_W-1:0] b);
        case (b)
            CH_SPACE, CH_TAB, CH_VT, CH_FF: return CC_WS;
            CH_CR, CH_LF: return CC_NL;
            CH_LPAREN: return CC_LP;
            CH_RPAREN: return CC_RP;
            CH_LBRACE: return CC_LB;
            CH_RBRACE: return CC_RB;
            CH_STAR:   return CC_STAR;
            CH_QUOTE:  return CC_QUOTE;
            CH_SLASH:  return CC_SLASH;
            default: ;
        endcase
        if (b >= CH_DIG0 && b <= CH_DIG9) return CC_DIG;
        if ((b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z) || b == CH_UNDER)
            return CC_LET;
        return CC_OTH;
    endfunction

    task automatic add_word_char(logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] ch;
        ch = (b >= CH_UC_A && b <= CH_UC_Z) ? (b | CASE_BIT) : b;
        if (word_len < MAX_KEYWORD_LEN) word_buf[word_len] = ch;
        if (word_len <= MAX_KEYWORD_LEN) word_len++;
    endtask

    function automatic bit word_is_keyword();
        bit hit;
        if (word_len == 0 || word_len > MAX_KEYWORD_LEN) return 1'b0;
        foreach (kw_list[i]) begin
            if (kw_list[i].len() == word_len) begin
                hit = 1'b1;
                for (int k = 0; k < word_len; k++) begin
                    if (kw_list[i][k] != word_buf[k]) hit = 1'b0;
                end
                if (hit) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [FMT_W-1:0] open_format();
        case (lx_mode)
            MODE_STR:   return FMT_STRING;
            MODE_LINE:  return FMT_COMMENT;
            MODE_BRACE,
            MODE_PCOM:  return dir_seen ? FMT_DIRECTIVE : FMT_COMMENT;
            MODE_IDENT: return word_is_keyword() ? FMT_KEYWORD : FMT_DEFAULT;
            default:    return FMT_DEFAULT;
        endcase
    endfunction

    task automatic close_seg(logic fin);
        result_t r;
        r.seg_length    = run_len;
        r.seg_format    = open_format();
        r.final_segment = fin;
        seg_q.push_back(r);
        lx_mode = MODE_IDLE;
    endtask

    task automatic open_seg(logic [CHAR_W-1:0] b, char_cls_t c);
        run_len     = SEG_LEN_BITS'(1);
        dir_seen    = 1'b0;
        want_dollar = 1'b0;
        last_star   = 1'b0;
        word_len    = 0;
        case (c)
            CC_WS, CC_NL: lx_mode = MODE_WS;
            CC_QUOTE:     lx_mode = MODE_STR;
            CC_SLASH:     lx_mode = MODE_SLASH;
            CC_LB: begin
                lx_mode     = MODE_BRACE;
                want_dollar = 1'b1;
            end
            CC_LP:        lx_mode = MODE_LPAR;
            CC_LET: begin
                lx_mode = MODE_IDENT;
                add_word_char(b);
            end
            default:      lx_mode = MODE_OTHER;
        endcase
    endtask

    // advance the shadow lexer by one accepted byte, queueing the segments it closes
    task automatic lex_byte(logic [CHAR_W-1:0] b, logic eot);
        char_cls_t c;
        bit        grow;
        bit        shut;
        c    = classify(b);
        grow = 1'b0;
        shut = 1'b0;
        case (lx_mode)
            MODE_WS:    grow = (c == CC_WS || c == CC_NL);
            MODE_STR: begin
                if (c == CC_QUOTE) begin
                    grow = 1'b1;
                    shut = 1'b1;
                end else begin
                    grow = (c != CC_NL);
                end
            end
            MODE_SLASH: begin
                if (c == CC_SLASH) begin
                    grow    = 1'b1;
                    lx_mode = MODE_LINE;
                end
            end
            MODE_LINE:  grow = (c != CC_NL);
            MODE_BRACE: begin
                if (want_dollar) begin
                    dir_seen    = (b == CH_DOLLAR);
                    want_dollar = 1'b0;
                end
                grow = 1'b1;
                shut = (c == CC_RB);
            end
            MODE_LPAR: begin
                if (c == CC_STAR) begin
                    grow        = 1'b1;
                    lx_mode     = MODE_PCOM;
                    want_dollar = 1'b1;
                    last_star   = 1'b0;
                end
            end
            MODE_PCOM: begin
                if (want_dollar) begin
                    dir_seen    = (b == CH_DOLLAR);
                    want_dollar = 1'b0;
                end
                grow      = 1'b1;
                shut      = (c == CC_RP) && last_star;
                last_star = (c == CC_STAR);
            end
            MODE_IDENT: begin
                if (c == CC_LET || c == CC_DIG) begin
                    grow = 1'b1;
                    add_word_char(b);
                end
            end
            MODE_OTHER: grow = c inside {CC_RP, CC_RB, CC_STAR, CC_DIG, CC_OTH};
            default:    lx_mode = MODE_IDLE;
        endcase
        if (grow) begin
            if (run_len != LEN_MAX) run_len++;
            if (shut) begin
                close_seg(eot);
                return;
            end
        end else begin
            if (lx_mode != MODE_IDLE) close_seg(1'b0);
            open_seg(b, c);
        end
        if (eot && lx_mode != MODE_IDLE) close_seg(1'b1);
    endtask

    // ---------------- stimulus builders ----------------
    task automatic put(logic [CHAR_W-1:0] b);
        src_byte_t e;
        e.b    = b;
        e.last = 1'b0;
        text_q.push_back(e);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic end_text();
        text_q[text_q.size()-1].last = 1'b1;
    endtask

    function automatic logic [CHAR_W-1:0] pick_letter();
        int r;
        r = $urandom_range(52);
        if (r == 52) return CH_UNDER;
        if (r < 26) return CH_LC_A + r[CHAR_W-1:0];
        return CH_UC_A + r[CHAR_W-1:0] - 8'd26;
    endfunction

    function automatic logic [CHAR_W-1:0] fill_byte();
        if ($urandom_range(3) == 0) return CHAR_W'($urandom_range(255));
        if ($urandom_range(5) == 0) return CH_SPACE;
        return CH_LC_A + CHAR_W'($urandom_range(25));
    endfunction

    task automatic put_token();
        tok_kind_t         kind;
        string             w;
        logic [CHAR_W-1:0] ch;
        int                n;
        kind = tok_kind_t'($urandom_range(TK_NOISE));
        case (kind)
            TK_KEYWORD: begin
                w = kw_list[$urandom_range(KW_N-1)];
                for (int i = 0; i < w.len(); i++) begin
                    ch = w[i];
                    if ($urandom_range(1) == 1) ch = ch ^ CASE_BIT;
                    put(ch);
                end
            end
            TK_IDENT: begin
                n = $urandom_range(1, 18);
                put(pick_letter());
                for (int i = 1; i < n; i++)
                    put(($urandom_range(3) == 0) ? CH_DIG0 + CHAR_W'($urandom_range(9))
                                                 : pick_letter());
            end
            TK_NUMBER: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) put(CH_DIG0 + CHAR_W'($urandom_range(9)));
            end
            TK_SPACE: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(5))
                        0: put(CH_SPACE);
                        1: put(CH_TAB);
                        2: put(CH_VT);
                        3: put(CH_FF);
                        4: put(CH_CR);
                        default: put(CH_LF);
                    endcase
                end
            end
            TK_STRING: begin
                put(CH_QUOTE);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) put(fill_byte());
                if ($urandom_range(4) != 0) put(CH_QUOTE);
                else put(CH_LF);
            end
            TK_BRACE: begin
                put(CH_LBRACE);
                if ($urandom_range(2) == 0) put(CH_DOLLAR);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) put(fill_byte());
                put(CH_RBRACE);
            end
            TK_PAREN: begin
                put(CH_LPAREN);
                put(CH_STAR);
                if ($urandom_range(2) == 0) put(CH_DOLLAR);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) put(($urandom_range(4) == 0) ? CH_STAR : fill_byte());
                put(CH_STAR);
                put(CH_RPAREN);
            end
            TK_LINE: begin
                put(CH_SLASH);
                put(CH_SLASH);
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++) put(fill_byte());
                put(($urandom_range(1) == 0) ? CH_LF : CH_CR);
            end
            TK_PUNCT: begin
                w = ")}*/(;:=+-.,<>[]^@";
                put(w[$urandom_range(w.len()-1)]);
            end
            default: put(CHAR_W'($urandom_range(255)));
        endcase
        if (kind != TK_SPACE && $urandom_range(1) == 0) put(CH_SPACE);
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) lex_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (text_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
                    nxt_byte = text_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt_byte.b;
                    s_tlast  <= nxt_byte.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- sink ready, with one long hold-off ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && seg_seen >= 60) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // ---------------- monitor ----------------
    task automatic flag(string what, int unsigned want, int unsigned got);
        if (err_cnt < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, what, want, got);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seg_seen++;
            if (seg_q.size() == 0) begin
                if (err_cnt < MAX_REPORTS)
                    $display("%0t: unexpected segment, expected none actual %h last %b",
                             $realtime, m_tdata, m_tlast);
                err_cnt++;
            end else begin
                if (m_tdata[SEG_LEN_BITS-1:0] != seg_q[0].seg_length)
                    flag("seg_length", seg_q[0].seg_length, m_tdata[SEG_LEN_BITS-1:0]);
                if (m_tdata[SEG_LEN_BITS +: FMT_W] != seg_q[0].seg_format)
                    flag("seg_format", seg_q[0].seg_format, m_tdata[SEG_LEN_BITS +: FMT_W]);
                if (m_tlast != seg_q[0].final_segment)
                    flag("final_segment", seg_q[0].final_segment, m_tlast);
                if (m_tdata[OUT_TDATA_W-1:SEG_LEN_BITS+FMT_W] != '0)
                    flag("tdata padding", 0, m_tdata[OUT_TDATA_W-1:SEG_LEN_BITS+FMT_W]);
                void'(seg_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > cyc_limit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int rnd_start;

        // keywords, mixed case, the longest keyword and one char past it
        put_str("BeGin Implementation implementations x_9Z if");
        end_text();
        // every whitespace byte, each comment and string form, other bytes and an open brace comment at end of text
        put(CH_TAB); put(CH_VT); put(CH_FF); put(CH_CR); put(CH_LF); put(CH_SPACE);
        put_str("{$i}{c}(*$r*)(*)*)(x/y//z");
        put(CH_LF);
        put_str("'ab''c");
        put(CH_LF);
        put_str(")}*09");
        put(8'h80); put(8'hFF); put(8'h00); put(8'h7F);
        put_str("{open");
        end_text();
        // unterminated string, paren comment and line comment at end of text
        put_str("'abc");
        end_text();
        put_str("(*x");
        end_text();
        put_str("//q");
        end_text();
        // lone slash and lone paren as the final byte
        put(CH_SLASH);
        end_text();
        put(CH_LPAREN);
        end_text();

        rnd_start = text_q.size();
        while (text_q.size() - rnd_start < RANDOM_BYTES) begin
            repeat ($urandom_range(1, 25)) put_token();
            end_text();
        end

        cyc_limit = 40 * text_q.size() + 20000;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() != 0 || s_tvalid || seg_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (err_cnt == 0 && seg_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
